### design/jitter_delay_estimator_assert.svh
// Assertion macros shared by the checker of the jitter delay estimator.
// Both sample on aclk and stay quiet while aresetn is low.
`ifndef JITTER_DELAY_ESTIMATOR_ASSERT_SVH
`define JITTER_DELAY_ESTIMATOR_ASSERT_SVH

// Same-cycle implication.
`define JDE_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("jitter delay estimator: same-cycle check failed");

// Next-cycle implication.
`define JDE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("jitter delay estimator: next-cycle check failed");

`endif

### design/jde_pkg.sv
package jde_pkg;

    localparam int SLOTS           = 16;
    localparam int MAX_DATA_OCTETS = 160;
    localparam int WORDS_PER_SLOT  = (MAX_DATA_OCTETS + 1) / 2;

    // slot index is the low bits of the sequence number, so SLOTS is a power of two
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int ADDR_W  = $clog2(SLOTS * WORDS_PER_SLOT);
    localparam int POS_W   = $clog2(MAX_DATA_OCTETS + 4);
    localparam int INDEX_W = 7;
    localparam int OCTET_W = 8;
    localparam int SEQ_W   = 16;
    localparam int TYPE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int TIME_W  = 32;
    localparam int PROD_W  = 24;
    localparam int STAT_W  = 40;
    localparam int LEN_W   = 15;
    localparam int CNT_W   = 32;
    localparam int CFG_W   = 8;
    localparam int SHIFT_W = 4;
    localparam int GAIN_W  = 4;
    localparam int MS_SHIFT = 7;

    localparam int SAMPLES_PER_SEQ = 160;
    localparam int JUMP_ZERO       = (10 * 160) << 4;
    localparam int JUMP_ONE        = (5 * 160) << 4;
    localparam int LENGTH_BASE     = 80 << 4;

    localparam int MIN_DELAY_RESET = 20;
    localparam int MAX_DELAY_RESET = 100;
    localparam int SHIFT_RESET     = 4;
    localparam int GAIN_RESET      = 2;

    localparam logic OP_OCTET = 1'b0;
    localparam logic OP_READ  = 1'b1;
    localparam logic RK_STATS = 1'b0;
    localparam logic RK_READ  = 1'b1;

    typedef enum logic [1:0] {
        RATE_NORMAL,
        RATE_HALF,
        RATE_JUMP
    } rate_t;

    typedef enum logic [1:0] {
        CFG_MIN_DELAY,
        CFG_MAX_DELAY,
        CFG_SMOOTH_SHIFT,
        CFG_DEV_GAIN
    } cfg_index_t;

    typedef struct packed {
        logic              emit;
        logic              kind;
        logic              stats;
        logic              short_pkt;
        logic              idx_ok;
        logic [SLOT_W-1:0] slot;
        logic [PROD_W-1:0] prod;
        logic [TIME_W-1:0] ltime;
    } front_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [TYPE_W-1:0] ptype;
        logic [WORD_W-1:0] word;
    } read_data_t;

endpackage

### design/jde_packer.sv
module jde_packer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           accept,
    input  logic                           s_operation,
    input  logic [jde_pkg::OCTET_W-1:0]    s_octet,
    input  logic                           s_last_octet,
    input  logic [jde_pkg::TIME_W-1:0]     s_local_time,
    input  logic [jde_pkg::SLOT_W-1:0]     s_read_slot,
    input  logic [jde_pkg::INDEX_W-1:0]    s_read_index,
    output jde_pkg::front_t                front,
    output jde_pkg::read_data_t            rd
);
    import jde_pkg::*;

    logic [WORD_W-1:0] word_mem [0:SLOTS*WORDS_PER_SLOT-1];
    logic [SEQ_W-1:0]  seq_mem  [0:SLOTS-1];
    logic [TYPE_W-1:0] type_mem [0:SLOTS-1];

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [23:0]        header_reg, header_next;
    logic [OCTET_W-1:0] hbyte_reg, hbyte_next;

    logic               octet_acc;
    logic               read_acc;
    logic [SEQ_W-1:0]   seq_new;
    logic [SLOT_W-1:0]  slot_cur;
    logic [POS_W-1:0]   data_pos;
    logic               data_ok;
    logic               word_we;
    logic [ADDR_W-1:0]  word_addr;
    logic [WORD_W-1:0]  word_wdata;
    logic               hdr_we;
    logic               idx_ok;
    logic [ADDR_W-1:0]  rd_addr;
    logic               is_last_octet;
    read_data_t         rd_reg;

    assign octet_acc     = accept && (s_operation == OP_OCTET);
    assign read_acc      = accept && (s_operation == OP_READ);
    assign is_last_octet = (s_operation == OP_OCTET) && s_last_octet;

    always_comb begin
        // the third octet completes the sequence number in the same cycle
        seq_new = (pos_reg == POS_W'(2)) ? {header_reg[15:8], s_octet} : header_reg[15:0];
        slot_cur = header_reg[SLOT_W-1:0];
        data_pos = pos_reg - POS_W'(3);
        data_ok  = (pos_reg >= POS_W'(3)) && (data_pos < POS_W'(MAX_DATA_OCTETS));
        word_addr = ADDR_W'(slot_cur) * ADDR_W'(WORDS_PER_SLOT)
                  + ADDR_W'(data_pos[POS_W-1:1]);
        word_wdata = data_pos[0] ? {hbyte_reg, s_octet} : {s_octet, 8'd0};
        word_we  = octet_acc && data_ok && (data_pos[0] || s_last_octet);
        hdr_we   = octet_acc && (pos_reg == POS_W'(2));

        header_next = header_reg;
        if (pos_reg == POS_W'(0)) begin
            header_next = {s_octet, 16'd0};
        end else if (pos_reg == POS_W'(1)) begin
            header_next = {header_reg[23:16], s_octet, header_reg[7:0]};
        end else if (pos_reg == POS_W'(2)) begin
            header_next = {header_reg[23:8], s_octet};
        end

        hbyte_next = hbyte_reg;
        if (data_ok && !data_pos[0]) begin
            hbyte_next = s_octet;
        end

        // hold the position once the data area is full
        if (s_last_octet) begin
            pos_next = '0;
        end else if (pos_reg < POS_W'(MAX_DATA_OCTETS + 3)) begin
            pos_next = pos_reg + POS_W'(1);
        end else begin
            pos_next = pos_reg;
        end

        idx_ok  = 32'(s_read_index) < WORDS_PER_SLOT;
        rd_addr = idx_ok ? (ADDR_W'(s_read_slot) * ADDR_W'(WORDS_PER_SLOT)
                            + ADDR_W'(s_read_index)) : '0;

        front = '0;
        front.emit      = (s_operation == OP_READ) || s_last_octet;
        front.kind      = (s_operation == OP_READ) ? RK_READ : RK_STATS;
        front.stats     = is_last_octet && (pos_reg >= POS_W'(2));
        front.short_pkt = is_last_octet && (pos_reg < POS_W'(2));
        front.idx_ok    = idx_ok;
        if (s_operation == OP_READ) begin
            front.slot = s_read_slot;
        end else if (pos_reg >= POS_W'(2)) begin
            front.slot = seq_new[SLOT_W-1:0];
        end
        front.prod  = PROD_W'(seq_new) * PROD_W'(SAMPLES_PER_SEQ);
        front.ltime = s_local_time;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            header_reg <= '0;
            hbyte_reg  <= '0;
        end else if (octet_acc) begin
            pos_reg    <= pos_next;
            header_reg <= header_next;
            hbyte_reg  <= hbyte_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (word_we) begin
            word_mem[word_addr] <= word_wdata;
        end
        if (hdr_we) begin
            seq_mem[seq_new[SLOT_W-1:0]]  <= seq_new;
            type_mem[seq_new[SLOT_W-1:0]] <= header_reg[23:16];
        end
        if (read_acc) begin
            rd_reg.seq   <= seq_mem[s_read_slot];
            rd_reg.ptype <= type_mem[s_read_slot];
            rd_reg.word  <= word_mem[rd_addr];
        end
    end

    assign rd = rd_reg;

endmodule

### design/jitter_delay_estimator.sv
// Jitter delay estimator.
// Input channel (s_valid/s_ready): one request per packet octet or per slot read.
// Octets of a packet arrive in order, s_last_octet on the final one; its
// s_local_time is used for the delay statistics. A read request returns the
// stored sequence number, payload type and one data word of a slot.
// Result channel (m_valid/m_ready): one result for each final octet and each
// read; other octets give none. Results leave in request order.
// Throughput: one request per cycle with m_ready high, set by the eight-register
// pipeline (input register, six arithmetic stages, output register).
// Path: a taken request passes through subtract, delay difference, magnitude
// test, average update, deviation update, gain multiply, then offset and clamp.
// Stall: while m_ready is low the output register holds; requests are still
// taken until the pipeline fills, then s_ready drops.
// Reset (aresetn low, synchronous): statistics, counter, packet position and
// configuration return to their defaults; slot memory is not cleared.
// Configuration (cfg_we/cfg_index/cfg_wdata) is to be written only while the
// block is idle; the user must keep to this, the block does not enforce it.
module jitter_delay_estimator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [jde_pkg::OCTET_W-1:0]   s_octet,
    input  logic                          s_last_octet,
    input  logic [jde_pkg::TIME_W-1:0]    s_local_time,
    input  logic [jde_pkg::SLOT_W-1:0]    s_read_slot,
    input  logic [jde_pkg::INDEX_W-1:0]   s_read_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_result_kind,
    output logic [jde_pkg::SLOT_W-1:0]    m_slot,
    output logic signed [jde_pkg::STAT_W-1:0] m_average_delay,
    output logic signed [jde_pkg::STAT_W-1:0] m_delay_deviation,
    output logic [jde_pkg::LEN_W-1:0]     m_playout_length,
    output logic [1:0]                    m_rate_code,
    output logic [jde_pkg::CNT_W-1:0]     m_packets_received,
    output logic                          m_short_packet,
    output logic [jde_pkg::SEQ_W-1:0]     m_read_sequence,
    output logic [jde_pkg::TYPE_W-1:0]    m_read_payload_type,
    output logic [jde_pkg::WORD_W-1:0]    m_read_word,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [jde_pkg::CFG_W-1:0]     cfg_wdata
);
    import jde_pkg::*;

    localparam int STAGES = 7;
    localparam int V_W    = STAT_W + 2;
    localparam int MUL_W  = STAT_W + GAIN_W + 1;

    typedef struct packed {
        logic               emit;
        logic               kind;
        logic [SLOT_W-1:0]  slot;
        logic               stats;
        logic               short_pkt;
        logic               idx_ok;
        logic [PROD_W-1:0]  prod;
        logic [TIME_W-1:0]  ltime;
        logic [37:0]        t;
        logic [V_W-1:0]     v;
        logic [SHIFT_W-1:0] sh;
        rate_t              rate;
        logic [15:0]        av_in;
        logic [V_W-1:0]     dv;
        logic [STAT_W-1:0]  avg_new;
        logic [STAT_W-1:0]  dev_new;
        logic [MUL_W-1:0]   len_mul;
        read_data_t         rdata;
    } pipe_t;

    typedef struct packed {
        logic               kind;
        logic [SLOT_W-1:0]  slot;
        logic [STAT_W-1:0]  avg;
        logic [STAT_W-1:0]  dev;
        logic [LEN_W-1:0]   len;
        rate_t              rate;
        logic [CNT_W-1:0]   cnt;
        logic               short_pkt;
        read_data_t         rdata;
    } out_t;

    front_t     front;
    read_data_t rd;
    logic       accept;

    pipe_t pipe_reg [0:STAGES-1];
    pipe_t p_next   [0:STAGES-1];
    logic [STAGES-1:0] vld_reg;
    logic [STAGES:0]   load;
    out_t  out_reg, out_next;
    logic  m_valid_reg;

    logic [CFG_W-1:0]   min_ms_reg, max_ms_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [GAIN_W-1:0]  gain_reg;

    // working copies feed the arithmetic; committed copies are what results show
    logic [STAT_W-1:0] avg_w_reg, dev_w_reg;
    logic [STAT_W-1:0] avg_c_reg, dev_c_reg;
    logic [LEN_W-1:0]  target_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic signed [33:0]    diff;
    logic [V_W-1:0]        mag;
    logic [V_W-1:0]        v_shr;
    logic [V_W-1:0]        dv_shr;
    logic signed [MUL_W:0] len_raw;
    logic signed [MUL_W:0] lo_bound, hi_bound;
    logic signed [MUL_W:0] len_lo, len_hi;

    assign accept = s_valid && s_ready;

    jde_packer u_packer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .s_operation  (s_operation),
        .s_octet      (s_octet),
        .s_last_octet (s_last_octet),
        .s_local_time (s_local_time),
        .s_read_slot  (s_read_slot),
        .s_read_index (s_read_index),
        .front        (front),
        .rd           (rd)
    );

    // advance a stage when it is empty or its successor advances
    always_comb begin
        load[STAGES] = !m_valid_reg || m_ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            load[k] = !vld_reg[k] || load[k+1];
        end
    end

    assign s_ready = load[0];

    always_comb begin
        p_next[0] = '0;
        p_next[0].emit      = front.emit;
        p_next[0].kind      = front.kind;
        p_next[0].slot      = front.slot;
        p_next[0].stats     = front.stats;
        p_next[0].short_pkt = front.short_pkt;
        p_next[0].idx_ok    = front.idx_ok;
        p_next[0].prod      = front.prod;
        p_next[0].ltime     = front.ltime;

        // remote minus local time, scaled by 16; pick up the read data
        p_next[1] = pipe_reg[0];
        diff = $signed({10'd0, pipe_reg[0].prod}) - $signed({2'd0, pipe_reg[0].ltime});
        p_next[1].t = {diff, 4'd0};
        p_next[1].rdata.seq   = rd.seq;
        p_next[1].rdata.ptype = rd.ptype;
        p_next[1].rdata.word  = pipe_reg[0].idx_ok ? rd.word : '0;

        p_next[2] = pipe_reg[1];
        p_next[2].v = $signed({{4{pipe_reg[1].t[37]}}, pipe_reg[1].t})
                    - $signed({{2{avg_w_reg[STAT_W-1]}}, avg_w_reg});

        // large jumps take a short shift; the largest reset the deviation input
        p_next[3] = pipe_reg[2];
        mag = pipe_reg[2].v[V_W-1] ? (~pipe_reg[2].v + V_W'(1)) : pipe_reg[2].v;
        if (mag > V_W'(JUMP_ZERO)) begin
            p_next[3].rate  = RATE_JUMP;
            p_next[3].sh    = '0;
            p_next[3].av_in = '0;
        end else if (mag > V_W'(JUMP_ONE)) begin
            p_next[3].rate  = RATE_HALF;
            p_next[3].sh    = SHIFT_W'(1);
            p_next[3].av_in = mag[15:0];
        end else begin
            p_next[3].rate  = RATE_NORMAL;
            p_next[3].sh    = shift_reg;
            p_next[3].av_in = mag[15:0];
        end

        p_next[4] = pipe_reg[3];
        v_shr = $signed(pipe_reg[3].v) >>> pipe_reg[3].sh;
        p_next[4].avg_new = avg_w_reg + v_shr[STAT_W-1:0];
        p_next[4].dv = $signed({{(V_W-16){1'b0}}, pipe_reg[3].av_in})
                     - $signed({{2{dev_w_reg[STAT_W-1]}}, dev_w_reg});

        p_next[5] = pipe_reg[4];
        dv_shr = $signed(pipe_reg[4].dv) >>> pipe_reg[4].sh;
        p_next[5].dev_new = dev_w_reg + dv_shr[STAT_W-1:0];

        p_next[6] = pipe_reg[5];
        p_next[6].len_mul = $signed({1'b0, gain_reg}) * $signed(pipe_reg[5].dev_new);
    end

    // offset, raise to the lower bound, then lower to the upper bound
    always_comb begin
        len_raw  = $signed({pipe_reg[6].len_mul[MUL_W-1], pipe_reg[6].len_mul})
                 + $signed((MUL_W+1)'(LENGTH_BASE));
        lo_bound = $signed({{(MUL_W+1-CFG_W-MS_SHIFT){1'b0}}, min_ms_reg, {MS_SHIFT{1'b0}}});
        hi_bound = $signed({{(MUL_W+1-CFG_W-MS_SHIFT){1'b0}}, max_ms_reg, {MS_SHIFT{1'b0}}});
        len_lo   = (len_raw < lo_bound) ? lo_bound : len_raw;
        len_hi   = (len_lo > hi_bound) ? hi_bound : len_lo;

        out_next.kind      = pipe_reg[6].kind;
        out_next.slot      = pipe_reg[6].slot;
        out_next.short_pkt = pipe_reg[6].short_pkt;
        if (pipe_reg[6].stats) begin
            out_next.avg  = pipe_reg[6].avg_new;
            out_next.dev  = pipe_reg[6].dev_new;
            out_next.len  = len_hi[LEN_W-1:0];
            out_next.rate = pipe_reg[6].rate;
            out_next.cnt  = cnt_reg + CNT_W'(1);
        end else begin
            out_next.avg  = avg_c_reg;
            out_next.dev  = dev_c_reg;
            out_next.len  = target_reg;
            out_next.rate = RATE_NORMAL;
            out_next.cnt  = cnt_reg;
        end
        if (pipe_reg[6].kind == RK_READ) begin
            out_next.rdata = pipe_reg[6].rdata;
        end else begin
            out_next.rdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (load[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            // drop octets that give no result before the output register
            if (load[STAGES]) begin
                m_valid_reg <= vld_reg[STAGES-1] && pipe_reg[STAGES-1].emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < STAGES; k++) begin
            if (load[k]) begin
                pipe_reg[k] <= p_next[k];
            end
        end
        if (load[STAGES]) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_w_reg  <= '0;
            dev_w_reg  <= '0;
            avg_c_reg  <= '0;
            dev_c_reg  <= '0;
            target_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (load[4] && vld_reg[3] && pipe_reg[3].stats) begin
                avg_w_reg <= p_next[4].avg_new;
            end
            if (load[5] && vld_reg[4] && pipe_reg[4].stats) begin
                dev_w_reg <= p_next[5].dev_new;
            end
            if (load[STAGES] && vld_reg[STAGES-1] && pipe_reg[STAGES-1].stats) begin
                avg_c_reg  <= out_next.avg;
                dev_c_reg  <= out_next.dev;
                target_reg <= out_next.len;
                cnt_reg    <= out_next.cnt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_ms_reg <= CFG_W'(MIN_DELAY_RESET);
            max_ms_reg <= CFG_W'(MAX_DELAY_RESET);
            shift_reg  <= SHIFT_W'(SHIFT_RESET);
            gain_reg   <= GAIN_W'(GAIN_RESET);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MIN_DELAY: begin
                    min_ms_reg <= cfg_wdata;
                end
                CFG_MAX_DELAY: begin
                    max_ms_reg <= cfg_wdata;
                end
                CFG_SMOOTH_SHIFT: begin
                    shift_reg <= cfg_wdata[SHIFT_W-1:0];
                end
                CFG_DEV_GAIN: begin
                    gain_reg <= cfg_wdata[GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_result_kind       = out_reg.kind;
    assign m_slot              = out_reg.slot;
    assign m_average_delay     = $signed(out_reg.avg);
    assign m_delay_deviation   = $signed(out_reg.dev);
    assign m_playout_length    = out_reg.len;
    assign m_rate_code         = out_reg.rate;
    assign m_packets_received  = out_reg.cnt;
    assign m_short_packet      = out_reg.short_pkt;
    assign m_read_sequence     = out_reg.rdata.seq;
    assign m_read_payload_type = out_reg.rdata.ptype;
    assign m_read_word         = out_reg.rdata.word;

endmodule

### design/jde_checker.sv
`include "jitter_delay_estimator_assert.svh"

module jde_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_result_kind,
    input logic [jde_pkg::SLOT_W-1:0]    m_slot,
    input logic [jde_pkg::LEN_W-1:0]     m_playout_length,
    input logic [1:0]                    m_rate_code,
    input logic [jde_pkg::CNT_W-1:0]     m_packets_received,
    input logic                          m_short_packet,
    input logic [jde_pkg::SEQ_W-1:0]     m_read_sequence,
    input logic [jde_pkg::TYPE_W-1:0]    m_read_payload_type,
    input logic [jde_pkg::WORD_W-1:0]    m_read_word
);
    import jde_pkg::*;

    // hold a stalled result
    `JDE_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_result_kind) && $stable(m_slot) && $stable(m_packets_received) && $stable(m_playout_length) && $stable(m_read_word))

    `JDE_ASSERT_IMPLY(a_read_flags, m_valid && (m_result_kind == RK_READ), (m_rate_code == RATE_NORMAL) && !m_short_packet)

    `JDE_ASSERT_IMPLY(a_stats_read_zero, m_valid && (m_result_kind == RK_STATS), (m_read_sequence == '0) && (m_read_payload_type == '0) && (m_read_word == '0))

    `JDE_ASSERT_IMPLY(a_short_packet, m_valid && m_short_packet, (m_slot == '0) && (m_rate_code == RATE_NORMAL) && (m_result_kind == RK_STATS))

endmodule

bind jitter_delay_estimator jde_checker u_checker (.*);
